@@ design/pir_pkg.sv @@
`default_nettype none

package pir_pkg;

    localparam int unsigned IDX_W     = 8;
    localparam int unsigned CHAN_W    = 8;
    localparam int unsigned ENTRY_W   = 3 * CHAN_W;
    localparam int unsigned PAL_DEPTH = 1 << IDX_W;

    localparam logic [IDX_W-1:0]  KEY_INDEX    = '1;
    localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = '1;
    localparam logic [CHAN_W-1:0] ALPHA_CLEAR  = '0;

    typedef enum logic {
        ACT_PAL_WRITE = 1'b0,
        ACT_PIXEL     = 1'b1
    } t_action;

    // palette write request towards the RAM
    typedef struct packed {
        logic                 en;
        logic [IDX_W-1:0]     addr;
        logic [ENTRY_W-1:0]   data;
    } t_pal_wr;

    // palette read request towards the RAM
    typedef struct packed {
        logic                 en;
        logic [IDX_W-1:0]     addr;
    } t_pal_rd;

endpackage

`default_nettype wire

@@ design/pir_palette_ram.sv @@
`default_nettype none

module pir_palette_ram
    import pir_pkg::*;
(
    input  wire logic               i_clk,
    input  wire t_pal_wr            i_wr,
    input  wire t_pal_rd            i_rd,
    output logic [ENTRY_W-1:0]      o_rd_data
);

    logic [ENTRY_W-1:0] r_mem [PAL_DEPTH];
    logic [ENTRY_W-1:0] r_rd_data;

    // hold read data while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

@@ design/palette_index_to_rgba.sv @@
// An accepted pixel request passes through stage 1 (the registered RAM read)
// and then the output register. Throughput: one request per cycle, pixel or
// palette write, while o_stall is low, set by the single palette RAM port
// pair (one write and one registered read each cycle).
// Reset: synchronous, active low; clears pipeline valids and the colour key.
// The palette RAM is not cleared and holds nothing meaningful until written.
`default_nettype none

module palette_index_to_rgba
    import pir_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,

    // configuration
    input  wire logic               i_cfg_wr_en,
    input  wire logic               i_cfg_wr_data,

    // request channel
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic               i_action,
    input  wire logic [IDX_W-1:0]   i_color_index,
    input  wire logic [CHAN_W-1:0]  i_entry_red,
    input  wire logic [CHAN_W-1:0]  i_entry_green,
    input  wire logic [CHAN_W-1:0]  i_entry_blue,
    input  wire logic               i_frame_end_in,

    // result channel
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [CHAN_W-1:0]       o_out_red,
    output logic [CHAN_W-1:0]       o_out_green,
    output logic [CHAN_W-1:0]       o_out_blue,
    output logic [CHAN_W-1:0]       o_out_alpha,
    output logic                    o_frame_end_out
);

    // Colour key register: write only while the block is idle (not enforced).
    logic r_key_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_en <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_key_en <= i_cfg_wr_data;
        end
    end

    // Pipeline: stage 1 waits on the RAM read, stage 2 is the output register.
    // A palette write completes in the cycle it is accepted and never enters
    // the pipeline. Reads and writes come from distinct requests, so one RAM
    // entry is never read and written at the same edge and a write is always
    // visible to the next pixel: no forwarding is needed.
    logic r_s1_valid;
    logic r_s1_keyed;
    logic r_s1_fe;
    logic r_out_valid;

    logic in_accept;
    logic is_pixel;
    logic keyed;
    logic s1_advance;

    t_pal_wr            pal_wr;
    t_pal_rd            pal_rd;
    logic [ENTRY_W-1:0] rd_data;

    assign s1_advance = r_s1_valid && (!r_out_valid || !i_stall);

    // Take a new request unless stage 1 is full and cannot drain this cycle.
    assign o_stall   = r_s1_valid && !s1_advance;
    assign in_accept = i_valid && !o_stall;
    assign is_pixel  = (i_action == ACT_PIXEL);
    assign keyed     = r_key_en && (i_color_index == KEY_INDEX);

    always_comb begin
        pal_wr.en   = in_accept && (i_action == ACT_PAL_WRITE);
        pal_wr.addr = i_color_index;
        pal_wr.data = {i_entry_red, i_entry_green, i_entry_blue};
        // skip the read for keyed pixels; their colour is forced to zero
        pal_rd.en   = in_accept && is_pixel && !keyed;
        pal_rd.addr = i_color_index;
    end

    pir_palette_ram u_ram (
        .i_clk     (i_clk),
        .i_wr      (pal_wr),
        .i_rd      (pal_rd),
        .o_rd_data (rd_data)
    );

    // Stage 1 control: advance whenever stage 1 empties or drains.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!r_s1_valid || s1_advance) begin
            r_s1_valid <= in_accept && is_pixel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && is_pixel) begin
            r_s1_keyed <= keyed;
            r_s1_fe    <= i_frame_end_in;
        end
    end

    // Output register: load from stage 1, hold while the consumer stalls.
    logic [CHAN_W-1:0] r_red;
    logic [CHAN_W-1:0] r_green;
    logic [CHAN_W-1:0] r_blue;
    logic [CHAN_W-1:0] r_alpha;
    logic              r_fe;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance) begin
            r_fe <= r_s1_fe;
            if (r_s1_keyed) begin
                r_red   <= '0;
                r_green <= '0;
                r_blue  <= '0;
                r_alpha <= ALPHA_CLEAR;
            end else begin
                r_red   <= rd_data[ENTRY_W-1 -: CHAN_W];
                r_green <= rd_data[2*CHAN_W-1 -: CHAN_W];
                r_blue  <= rd_data[CHAN_W-1:0];
                r_alpha <= ALPHA_OPAQUE;
            end
        end
    end

    assign o_valid         = r_out_valid;
    assign o_out_red       = r_red;
    assign o_out_green     = r_green;
    assign o_out_blue      = r_blue;
    assign o_out_alpha     = r_alpha;
    assign o_frame_end_out = r_fe;

`ifndef NO_ASSERTIONS
    // a transparent result carries no colour
    a_keyed_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_out_alpha == ALPHA_CLEAR) |->
            (o_out_red == '0) && (o_out_green == '0) && (o_out_blue == '0))
        else $error("keyed result carries colour");

    // alpha is either opaque or clear
    a_alpha_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_out_alpha == ALPHA_OPAQUE) || (o_out_alpha == ALPHA_CLEAR))
        else $error("alpha neither opaque nor clear");

    // input stalls only when both stages are occupied
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_s1_valid && r_out_valid && i_stall)
        else $error("stall raised with room in pipeline");

    // a held pixel in stage 1 is not lost
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s1_advance |=> r_s1_valid)
        else $error("stage 1 pixel dropped");
`endif

endmodule

`default_nettype wire
